### design/mbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
// Used by every module of the block and by its checker; depends on nothing.
package mbp_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BYTE_BITS = 8;
    localparam logic [5:0]  FULL_FREE = 6'd32;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [2:0]           t_bcnt;

    typedef struct packed {
        logic       command;
        t_word      value;
        logic [5:0] bit_count;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } t_out_beat;

    // A finished word handed from the packing stage to the byte serializer.
    typedef struct packed {
        logic  valid;
        t_word word;
        t_bcnt cnt;
    } t_load;

endpackage

### design/msb_first_bit_packer_top.sv
// Top level of the MSB-first bit packer.
// Depends on mbp_pkg, mbp_pack and mbp_ser.
//
// The packer takes one command beat per cycle while its input is not
// stalled: an append of 0 to 32 bits (counts above 32 are treated as 32,
// value bits above the count are ignored) or a flush. Bits fill a 32-bit
// word from the top down. Once a word is complete and more bits arrive, it
// leaves as four byte beats, high byte first; a flush sends the bytes that
// hold written bits, rounded up to whole bytes, and clears the word. The
// last byte beat caused by one command carries last. An accepted command
// sits in the input register while the packing logic works out the new word
// and any bytes it yields; those bytes are loaded into the output buffer as
// the command leaves the input register, and the output buffer offers them
// as byte beats. Commands that yield no bytes go through at one per cycle
// without waiting. A command that yields bytes waits in the input register,
// stalling the input, until the output buffer is empty or its final byte is
// being taken. A full word then holds the single output byte port for four
// byte beats, so the byte port, not the packing logic, sets the rate
// whenever words complete faster than the byte port can send their bytes.
module msb_first_bit_packer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mbp_pkg::t_in_beat  i_in,
    output logic               o_valid,
    input  logic               i_stall,
    output mbp_pkg::t_out_beat o_out
);

    mbp_pkg::t_load load;
    logic           ser_free;

    // Packing stage: holds the accumulator and turns each command into a
    // new state and, where needed, a word with a byte count.
    mbp_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in       (i_in),
        .o_stall    (o_stall),
        .i_ser_free (ser_free),
        .o_load     (load)
    );

    // Output buffer: sends the loaded word one byte beat at a time.
    mbp_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .o_free  (ser_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

endmodule

### design/mbp_pack.sv
// Input register, accumulator state and the single-pass packing logic.
// Depends on mbp_pkg; hands finished words to mbp_ser.
module mbp_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mbp_pkg::t_in_beat i_in,
    output logic              o_stall,
    input  logic              i_ser_free,
    output mbp_pkg::t_load    o_load
);

    logic              r_in_valid;
    mbp_pkg::t_in_beat r_in;
    mbp_pkg::t_word    r_acc;
    logic [5:0]        r_free;

    mbp_pkg::t_word n_acc;
    logic [5:0]     n_free;

    logic [5:0]     n_bits;
    logic [32:0]    mask33;
    mbp_pkg::t_word vmask;
    logic [5:0]     sh_fit;
    logic [5:0]     spill;
    logic [5:0]     sh_new;
    logic [5:0]     used;
    logic [6:0]     used_rnd;
    logic           needs_out;
    logic           advance;
    mbp_pkg::t_word out_word;
    mbp_pkg::t_bcnt out_cnt;

    always_comb begin
        n_bits   = (r_in.bit_count > mbp_pkg::FULL_FREE) ? mbp_pkg::FULL_FREE
                                                         : r_in.bit_count;
        mask33   = (33'd1 << n_bits) - 33'd1;
        vmask    = r_in.value & mask33[31:0];
        sh_fit   = r_free - n_bits;
        spill    = n_bits - r_free;
        sh_new   = mbp_pkg::FULL_FREE - spill;
        used     = mbp_pkg::FULL_FREE - r_free;
        used_rnd = {1'b0, used} + 7'd7;

        n_acc     = r_acc;
        n_free    = r_free;
        needs_out = 1'b0;
        out_word  = r_acc;
        out_cnt   = 3'd4;

        if (r_in.command == mbp_pkg::CMD_FLUSH) begin
            if (r_free != mbp_pkg::FULL_FREE) begin
                needs_out = 1'b1;
                out_cnt   = used_rnd[5:3];
                n_acc     = '0;
                n_free    = mbp_pkg::FULL_FREE;
            end
        end else if (r_free >= n_bits) begin
            n_acc  = r_acc | (vmask << sh_fit);
            n_free = sh_fit;
        end else begin
            // The upper part of the field completes the word; the rest starts the next one.
            needs_out = 1'b1;
            out_word  = r_acc | (vmask >> spill);
            n_acc     = vmask << sh_new;
            n_free    = sh_new;
        end
    end

    assign advance = r_in_valid && (!needs_out || i_ser_free);
    assign o_stall = r_in_valid && !advance;

    assign o_load.valid = advance && needs_out;
    assign o_load.word  = out_word;
    assign o_load.cnt   = out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_acc      <= '0;
            r_free     <= mbp_pkg::FULL_FREE;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_acc  <= n_acc;
                r_free <= n_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_in;
        end
    end

endmodule

### design/mbp_ser.sv
// Output word buffer that sends a finished word as bytes, high byte first.
// Depends on mbp_pkg; loaded by mbp_pack.
module mbp_ser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbp_pkg::t_load     i_load,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_stall,
    output mbp_pkg::t_out_beat o_out
);

    mbp_pkg::t_word r_word;
    mbp_pkg::t_bcnt r_cnt;

    // The buffer can take a new word now or as the final byte leaves.
    assign o_free = (r_cnt == 3'd0) || (r_cnt == 3'd1 && !i_stall);

    assign o_valid        = (r_cnt != 3'd0);
    assign o_out.out_byte = r_word[31:24];
    assign o_out.last     = (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load.valid) begin
            r_cnt <= i_load.cnt;
        end else if (o_valid && !i_stall) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_word <= i_load.word;
        end else if (o_valid && !i_stall) begin
            r_word <= {r_word[23:0], 8'h00};
        end
    end

endmodule

### design/mbp_checker.sv
// Port-level checker for the MSB-first bit packer, bound to the top level.
// Depends on mbp_pkg.
module mbp_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input mbp_pkg::t_in_beat  i_in,
    input logic               o_valid,
    input logic               i_stall,
    input mbp_pkg::t_out_beat o_out
);

    // A stalled byte beat stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output byte beat changed while stalled");

    // Once the bytes of one word have begun, valid stays up until its last byte is taken.
    a_word_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last && !i_stall |=> o_valid)
        else $error("gap inside the bytes of one word");

    // With no byte pending, the output buffer is free and input never waits.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while no byte was pending");

    // Reset leaves no byte pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("byte beat valid right after reset");

endmodule

bind msb_first_bit_packer_top mbp_port_checker u_chk (.*);

### tb/mbp_checker.sv
// Scoreboard for the MSB-first bit packer: watches both channels, predicts the byte beats.
// Depends on mbp_pkg for the beat structs and command codes.
module mbp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  mbp_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  mbp_pkg::t_out_beat i_out_beat,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the packer state: the partial word and its free low bits.
    mbp_pkg::t_word     shadow_word;
    logic [5:0]         shadow_free;
    mbp_pkg::t_out_beat owed_bytes[$];

    // Queue the leading bytes of a word, high byte first, with last on the final one.
    task automatic queue_word_bytes(input mbp_pkg::t_word w, input int unsigned n_bytes);
        mbp_pkg::t_out_beat b;
        for (int i = 0; i < n_bytes; i++) begin
            b.out_byte = w[mbp_pkg::WORD_BITS-1-8*i -: 8];
            b.last     = (i == n_bytes - 1);
            owed_bytes.push_back(b);
        end
    endtask

    task automatic pack_field(input mbp_pkg::t_in_beat b);
        int unsigned width;
        int unsigned spill;
        logic [63:0] field;
        if (b.command == mbp_pkg::CMD_FLUSH) begin
            if (shadow_free < mbp_pkg::FULL_FREE) begin
                queue_word_bytes(shadow_word, (mbp_pkg::WORD_BITS - shadow_free + 7) / 8);
                shadow_word = '0;
                shadow_free = mbp_pkg::FULL_FREE;
            end
        end else begin
            width = (b.bit_count > mbp_pkg::WORD_BITS) ? mbp_pkg::WORD_BITS : b.bit_count;
            field = {32'b0, b.value} & ((64'd1 << width) - 64'd1);
            if (shadow_free >= width) begin
                shadow_word = shadow_word
                            | mbp_pkg::t_word'(field << (shadow_free - width));
                shadow_free = 6'(shadow_free - width);
            end else begin
                // The field straddles the word boundary: its top part completes the
                // word, which goes out whole, and the rest opens the next word.
                spill       = width - shadow_free;
                shadow_word = shadow_word | mbp_pkg::t_word'(field >> spill);
                queue_word_bytes(shadow_word, 4);
                shadow_word = mbp_pkg::t_word'((field & ((64'd1 << spill) - 64'd1))
                                               << (mbp_pkg::WORD_BITS - spill));
                shadow_free = 6'(mbp_pkg::WORD_BITS - spill);
            end
        end
    endtask

    always @(posedge i_clk) begin
        mbp_pkg::t_out_beat want;
        if (!i_rst_n) begin
            shadow_word = '0;
            shadow_free = mbp_pkg::FULL_FREE;
            owed_bytes.delete();
        end else begin
            // Results pass through the input register and then the output buffer,
            // so the output beat of this edge never belongs to the input beat of this edge.
            if (i_out_valid && !i_out_stall) begin
                if (owed_bytes.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected byte beat, expected none, got byte %02h last %0b",
                             $time, i_out_beat.out_byte, i_out_beat.last);
                end else begin
                    want = owed_bytes.pop_front();
                    if (want.out_byte !== i_out_beat.out_byte
                        || want.last !== i_out_beat.last) begin
                        o_errors++;
                        $display({"%0t: byte beat mismatch, expected byte %02h last %0b,",
                                  " got byte %02h last %0b"},
                                 $time, want.out_byte, want.last,
                                 i_out_beat.out_byte, i_out_beat.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pack_field(i_in_beat);
            end
        end
        o_pending = owed_bytes.size();
    end

endmodule

### tb/msb_first_bit_packer_top_tb.sv
// Stimulus and verdict for the MSB-first bit packer; the checking lives in mbp_checker.
// Depends on mbp_pkg, mbp_checker and msb_first_bit_packer_top.
module msb_first_bit_packer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit; the slowest correct run stays well below it.
    localparam int CYCLE_LIMIT  = 100000;
    // The receiver's long hold-off; far longer than any buffering in the block.
    localparam int HOLD_CYCLES  = 64;
    // Cycles to watch after the last byte for anything stray.
    localparam int DRAIN_CYCLES = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    mbp_pkg::t_in_beat  i_in;
    logic               o_valid;
    logic               i_stall;
    mbp_pkg::t_out_beat o_out;

    int byte_errors;
    int bytes_owed;
    int cycles;

    // Knobs shared between the sequence and the two channel drivers.
    bit sender_idle_on = 1'b1;
    bit recv_idle_on   = 1'b1;
    bit hold_req       = 1'b0;

    msb_first_bit_packer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    mbp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_beat   (i_in),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_beat  (o_out),
        .o_errors    (byte_errors),
        .o_pending   (bytes_owed)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watchdog. A hung handshake anywhere ends the run here as a failure.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver side. It normally stalls at random, but when the sequence raises
    // hold_req it keeps stall high for a long stretch, counted here, so that the
    // block backs up and has to stall its input. The request is cleared once the
    // stretch is over.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= recv_idle_on && ($urandom_range(99) < 37);
        end
    end

    function automatic mbp_pkg::t_in_beat make_beat(input logic cmd,
                                                    input mbp_pkg::t_word value,
                                                    input logic [5:0] count);
        mbp_pkg::t_in_beat b;
        b.command   = cmd;
        b.value     = value;
        b.bit_count = count;
        return b;
    endfunction

    // Random commands: mostly appends with short fields, some full-word and
    // oversized counts, an occasional flush, and now and then an all-zero or
    // all-one value so both extremes keep showing up in the packed bytes.
    function automatic mbp_pkg::t_in_beat random_beat();
        mbp_pkg::t_in_beat b;
        int unsigned       pick;
        pick      = $urandom_range(99);
        b.command = (pick < 10) ? mbp_pkg::CMD_FLUSH : mbp_pkg::CMD_APPEND;
        b.value   = $urandom();
        case ($urandom_range(7))
            0: begin
                b.value = '0;
            end
            1: begin
                b.value = '1;
            end
            default: begin
            end
        endcase
        pick = $urandom_range(99);
        if (pick < 5) begin
            b.bit_count = 6'($urandom_range(63, 33));
        end else if (pick < 15) begin
            b.bit_count = 6'd32;
        end else begin
            b.bit_count = 6'($urandom_range(31));
        end
        return b;
    endfunction

    // Offer one beat, starting and ending at a falling edge. Random idle cycles
    // go in front of it; once valid is up it stays up, with the payload held,
    // until the block takes the beat at a rising edge without stall.
    task automatic send_beat(input mbp_pkg::t_in_beat b);
        while (sender_idle_on && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the input channel quiet until every predicted byte has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (bytes_owed != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A full-width field fills the word exactly and is held;
        // a zero-width append leaves it alone; the next one-bit append pushes
        // the held word out whole and starts a fresh word.
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd32));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h1234_5678, 6'd0));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h0000_0001, 6'd1));
        // A flush of a single bit rounds up to one byte; a second flush is empty.
        send_beat(make_beat(mbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0));
        send_beat(make_beat(mbp_pkg::CMD_FLUSH,  32'hFFFF_FFFF, 6'd63));
        // The largest count saturates to a whole word.
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'hA5A5_A5A5, 6'd63));
        // Value bits above the count must be dropped.
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'hFFFF_FFE3, 6'd5));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h0000_0000, 6'd0));
        // A long field that straddles the word boundary.
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h7FFF_FFFF, 6'd31));
        send_beat(make_beat(mbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0));
        // Short fields that fill exactly one byte, then a field that leaves a partial byte for the flush to round up.
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h0000_0003, 6'd2));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h0000_0000, 6'd6));
        send_beat(make_beat(mbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h0000_01FF, 6'd9));
        send_beat(make_beat(mbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0));
        // Just past 32 also saturates, here with most of the field spilling over.
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h00FF_FFFF, 6'd24));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'hABCD_EF01, 6'd33));
        send_beat(make_beat(mbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h8000_0001, 6'd32));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h0000_0055, 6'd8));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd40));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'h0000_0000, 6'd32));
        send_beat(make_beat(mbp_pkg::CMD_APPEND, 32'hDEAD_BEEF, 6'd17));
        send_beat(make_beat(mbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0));

        // The sender pauses here until every byte owed so far has arrived.
        wait_drained();

        // Random traffic with idle cycles on both sides.
        repeat (100) send_beat(random_beat());
        wait_drained();

        // A stretch with no idling at all. At its start the receiver holds off
        // for a long while as the sender keeps offering beats back to back, so
        // the block fills and stalls its input; afterwards both run flat out.
        sender_idle_on = 1'b0;
        recv_idle_on   = 1'b0;
        hold_req       = 1'b1;
        repeat (60) send_beat(random_beat());

        // Back to random idling for the tail, closed by a flush so that the
        // last partial word is seen as well.
        sender_idle_on = 1'b1;
        recv_idle_on   = 1'b1;
        repeat (40) send_beat(random_beat());
        send_beat(make_beat(mbp_pkg::CMD_FLUSH, 32'h0000_0000, 6'd0));

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (byte_errors == 0 && bytes_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
